### rtl/spp_pkg.sv
// Shared constants, types and control codes of the stereo ping-pong delay.
package spp_pkg;

  localparam int unsigned SAMPLE_WIDTH = 24;
  localparam int unsigned DELAY_DEPTH  = 262144;
  localparam int unsigned ADDR_W       = $clog2(DELAY_DEPTH);
  localparam int unsigned MEM_W        = 2 * SAMPLE_WIDTH;

  localparam int unsigned DLY_W      = 18;
  localparam int unsigned FB_W       = 16;
  localparam int unsigned GAIN_W     = 17;
  localparam int unsigned TONE_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned CMP_W      = ((ADDR_W > DLY_W) ? ADDR_W : DLY_W) + 1;

  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned FB_SHIFT = 32;
  localparam int unsigned MUL_A_W  = SAMPLE_WIDTH + 3;
  localparam int unsigned MUL_B_W  = GAIN_W + 1;
  localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W    = SAMPLE_WIDTH + GAIN_W + 1;
  localparam int unsigned HI_W     = ACC_W - FRAC_W;
  localparam int unsigned SUM_W    = PROD_W + FRAC_W + 1;
  localparam int unsigned SAT_W    = SAMPLE_WIDTH + 8;

  localparam logic [DLY_W-1:0]  DLY_RESET  = DLY_W'(1);
  localparam logic [TONE_W-1:0] TONE_RESET = {TONE_W{1'b1}};
  localparam logic [FB_W-1:0]   FB_MAX     = FB_W'(64225);
  localparam logic [GAIN_W-1:0] UNITY      = GAIN_W'(65536);

  localparam logic [CMP_W-1:0]  DLY_MAX    = CMP_W'(DELAY_DEPTH - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DELAY_DEPTH - 1);
  localparam logic [ADDR_W:0]   DEPTH_X    = (ADDR_W + 1)'(DELAY_DEPTH);

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [SUM_W-1:0]  FB_HALF  = SUM_W'(1) <<< (FB_SHIFT - 1);
  localparam logic signed [SAT_W-1:0]  SAT_HI   = (SAT_W'(1) <<< (SAMPLE_WIDTH - 1)) - SAT_W'(1);
  localparam logic signed [SAT_W-1:0]  SAT_LO   = ~SAT_HI;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY    = 3'd0,
    REG_FEEDBACK = 3'd1,
    REG_PINGPONG = 3'd2,
    REG_TONE     = 3'd3,
    REG_WET      = 3'd4
  } reg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef enum logic [3:0] {
    S_READ   = 4'd0,
    S_TONE_L = 4'd1,
    S_TONE_R = 4'd2,
    S_BL_L   = 4'd3,
    S_BL_R   = 4'd4,
    S_BR_R   = 4'd5,
    S_BR_L   = 4'd6,
    S_FBH_L  = 4'd7,
    S_FBL_L  = 4'd8,
    S_FBH_R  = 4'd9,
    S_FBL_R  = 4'd10,
    S_WET_L  = 4'd11,
    S_WET_R  = 4'd12,
    S_OUT_R  = 4'd13,
    S_DONE   = 4'd14
  } step_e;

  typedef struct packed {
    logic [ADDR_W-1:0] delay;
    logic [FB_W-1:0]   feedback;
    logic [GAIN_W-1:0] pingpong;
    logic [GAIN_W-1:0] keep;
    logic [TONE_W-1:0] tone;
    logic [GAIN_W-1:0] wet;
  } coef_t;

  typedef struct packed {
    logic  load;
    logic  run;
    step_e step;
    logic  rd_hit;
  } ctrl_t;

endpackage

### rtl/spp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module spp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/spp_cfg.sv
// Configuration registers and clamped coefficient set.
module spp_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [spp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [spp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output spp_pkg::coef_t                   coef_o
);
  import spp_pkg::*;

  logic [DLY_W-1:0]  delay_q, delay_d;
  logic [FB_W-1:0]   feedback_q, feedback_d;
  logic [GAIN_W-1:0] pingpong_q, pingpong_d;
  logic [TONE_W-1:0] tone_q, tone_d;
  logic [GAIN_W-1:0] wet_q, wet_d;
  logic [CMP_W-1:0]  delay_ext;
  logic [GAIN_W-1:0] pp_lim;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    delay_d    = delay_q;
    feedback_d = feedback_q;
    pingpong_d = pingpong_q;
    tone_d     = tone_q;
    wet_d      = wet_q;
    if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_DELAY:    delay_d    = cfg_data_i[DLY_W-1:0];
        REG_FEEDBACK: feedback_d = cfg_data_i[FB_W-1:0];
        REG_PINGPONG: pingpong_d = cfg_data_i[GAIN_W-1:0];
        REG_TONE:     tone_d     = cfg_data_i[TONE_W-1:0];
        REG_WET:      wet_d      = cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q    <= DLY_RESET;
      feedback_q <= '0;
      pingpong_q <= '0;
      tone_q     <= TONE_RESET;
      wet_q      <= '0;
    end else begin
      delay_q    <= delay_d;
      feedback_q <= feedback_d;
      pingpong_q <= pingpong_d;
      tone_q     <= tone_d;
      wet_q      <= wet_d;
    end
  end

  assign delay_ext = CMP_W'(delay_q);
  assign pp_lim    = (pingpong_q > UNITY) ? UNITY : pingpong_q;

  always_comb begin
    if (delay_ext == '0) begin
      coef_o.delay = ADDR_W'(1);
    end else if (delay_ext > DLY_MAX) begin
      coef_o.delay = LAST_ADDR;
    end else begin
      coef_o.delay = delay_ext[ADDR_W-1:0];
    end
    coef_o.feedback = (feedback_q > FB_MAX) ? FB_MAX : feedback_q;
    coef_o.pingpong = pp_lim;
    coef_o.keep     = UNITY - pp_lim;
    coef_o.tone     = tone_q;
    coef_o.wet      = (wet_q > UNITY) ? UNITY : wet_q;
  end

endmodule

### rtl/spp_dsp.sv
// Shared-multiplier datapath: damping filters, ping-pong feedback and wet mix.
module spp_dsp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  spp_pkg::ctrl_t                         ctrl_i,
  input  spp_pkg::coef_t                         coef_i,
  input  logic signed [spp_pkg::SAMPLE_WIDTH-1:0] left_in_i,
  input  logic signed [spp_pkg::SAMPLE_WIDTH-1:0] right_in_i,
  input  logic [spp_pkg::MEM_W-1:0]              rd_data_i,
  output logic [spp_pkg::MEM_W-1:0]              push_o,
  output logic signed [spp_pkg::SAMPLE_WIDTH-1:0] left_out_o,
  output logic signed [spp_pkg::SAMPLE_WIDTH-1:0] right_out_o
);
  import spp_pkg::*;

  function automatic logic signed [SAMPLE_WIDTH-1:0] saturate(
    input logic signed [SAT_W-1:0] v
  );
    logic signed [SAT_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end else begin
      r = v;
    end
    return r[SAMPLE_WIDTH-1:0];
  endfunction

  logic signed [SAMPLE_WIDTH-1:0] in_l_q, in_r_q;
  logic signed [SAMPLE_WIDTH-1:0] lp_l_q, lp_r_q;
  logic signed [SAMPLE_WIDTH-1:0] tap_l, tap_r;
  logic signed [SAMPLE_WIDTH:0]   diff_l, diff_r;
  logic signed [MUL_A_W-1:0]      mul_a;
  logic signed [MUL_B_W-1:0]      mul_b;
  logic signed [PROD_W-1:0]       prod_q;
  logic signed [PROD_W-1:0]       prod_rnd;
  logic signed [PROD_W-1:0]       prod_shr;
  logic signed [SAMPLE_WIDTH-1:0] lp_step;
  logic signed [ACC_W-1:0]        acc_l_q, acc_r_q;
  logic signed [HI_W-1:0]         acc_l_hi, acc_r_hi;
  logic [FRAC_W-1:0]              acc_l_lo, acc_r_lo;
  logic signed [PROD_W-1:0]       hi_q;
  logic signed [SUM_W-1:0]        fb_sum, fb_shr;
  logic signed [SAMPLE_WIDTH-1:0] fb_in, wet_in;
  logic signed [SAT_W-1:0]        push_val, out_val;
  logic signed [SAMPLE_WIDTH-1:0] push_l_q, push_r_q;
  logic signed [SAMPLE_WIDTH-1:0] out_l_q, out_r_q;

  assign tap_l = ctrl_i.rd_hit ? rd_data_i[MEM_W-1:SAMPLE_WIDTH] : '0;
  assign tap_r = ctrl_i.rd_hit ? rd_data_i[SAMPLE_WIDTH-1:0] : '0;
  assign diff_l = {tap_l[SAMPLE_WIDTH-1], tap_l} - {lp_l_q[SAMPLE_WIDTH-1], lp_l_q};
  assign diff_r = {tap_r[SAMPLE_WIDTH-1], tap_r} - {lp_r_q[SAMPLE_WIDTH-1], lp_r_q};

  assign acc_l_hi = acc_l_q[ACC_W-1:FRAC_W];
  assign acc_r_hi = acc_r_q[ACC_W-1:FRAC_W];
  assign acc_l_lo = acc_l_q[FRAC_W-1:0];
  assign acc_r_lo = acc_r_q[FRAC_W-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl_i.step)
      S_TONE_L: begin
        mul_a = MUL_A_W'(diff_l);
        mul_b = MUL_B_W'(coef_i.tone);
      end
      S_TONE_R: begin
        mul_a = MUL_A_W'(diff_r);
        mul_b = MUL_B_W'(coef_i.tone);
      end
      S_BL_L: begin
        mul_a = MUL_A_W'(lp_l_q);
        mul_b = MUL_B_W'(coef_i.keep);
      end
      S_BL_R: begin
        mul_a = MUL_A_W'(lp_r_q);
        mul_b = MUL_B_W'(coef_i.pingpong);
      end
      S_BR_R: begin
        mul_a = MUL_A_W'(lp_r_q);
        mul_b = MUL_B_W'(coef_i.keep);
      end
      S_BR_L: begin
        mul_a = MUL_A_W'(lp_l_q);
        mul_b = MUL_B_W'(coef_i.pingpong);
      end
      S_FBH_L: begin
        mul_a = MUL_A_W'(acc_l_hi);
        mul_b = MUL_B_W'(coef_i.feedback);
      end
      S_FBL_L: begin
        mul_a = MUL_A_W'(acc_l_lo);
        mul_b = MUL_B_W'(coef_i.feedback);
      end
      S_FBH_R: begin
        mul_a = MUL_A_W'(acc_r_hi);
        mul_b = MUL_B_W'(coef_i.feedback);
      end
      S_FBL_R: begin
        mul_a = MUL_A_W'(acc_r_lo);
        mul_b = MUL_B_W'(coef_i.feedback);
      end
      S_WET_L: begin
        mul_a = MUL_A_W'(lp_l_q);
        mul_b = MUL_B_W'(coef_i.wet);
      end
      S_WET_R: begin
        mul_a = MUL_A_W'(lp_r_q);
        mul_b = MUL_B_W'(coef_i.wet);
      end
      default: ;
    endcase
  end

  assign prod_rnd = prod_q + RND_HALF;
  assign prod_shr = prod_rnd >>> FRAC_W;
  assign lp_step  = prod_shr[SAMPLE_WIDTH-1:0];

  assign fb_sum   = (SUM_W'(hi_q) <<< FRAC_W) + SUM_W'(prod_q) + FB_HALF;
  assign fb_shr   = fb_sum >>> FB_SHIFT;
  assign fb_in    = (ctrl_i.step == S_WET_L) ? in_r_q : in_l_q;
  assign push_val = SAT_W'(fb_in) + fb_shr[SAT_W-1:0];

  assign wet_in  = (ctrl_i.step == S_OUT_R) ? in_r_q : in_l_q;
  assign out_val = SAT_W'(wet_in) + prod_shr[SAT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_l_q <= '0;
      lp_r_q <= '0;
    end else if (ctrl_i.run) begin
      if (ctrl_i.step == S_TONE_R) begin
        lp_l_q <= lp_l_q + lp_step;
      end
      if (ctrl_i.step == S_BL_L) begin
        lp_r_q <= lp_r_q + lp_step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      in_l_q <= left_in_i;
      in_r_q <= right_in_i;
    end
    if (ctrl_i.run) begin
      prod_q <= mul_a * mul_b;
      unique case (ctrl_i.step)
        S_BL_R:  acc_l_q  <= ACC_W'(prod_q);
        S_BR_R:  acc_l_q  <= acc_l_q + ACC_W'(prod_q);
        S_BR_L:  acc_r_q  <= ACC_W'(prod_q);
        S_FBH_L: acc_r_q  <= acc_r_q + ACC_W'(prod_q);
        S_FBL_L: hi_q     <= prod_q;
        S_FBH_R: push_l_q <= saturate(push_val);
        S_FBL_R: hi_q     <= prod_q;
        S_WET_L: push_r_q <= saturate(push_val);
        S_WET_R: out_l_q  <= saturate(out_val);
        S_OUT_R: out_r_q  <= saturate(out_val);
        default: ;
      endcase
    end
  end

  assign push_o      = {push_l_q, push_r_q};
  assign left_out_o  = out_l_q;
  assign right_out_o = out_r_q;

endmodule

### rtl/stereo_pingpong_delay_core.sv
// Top level of the stereo ping-pong delay: sequencer, delay memory and output register.
// Each stereo pair steps through memory read, 12 products on one shared multiplier, final
// saturation, hand-off to the output register and a return to idle, where the next pair is
// accepted; a held result stalls the next item at hand-off. Reset: configuration to defaults,
// filters and write position clear; unwritten memory entries read as zero by fill tracking,
// no clearing pass.
module stereo_pingpong_delay_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [spp_pkg::SAMPLE_WIDTH-1:0] left_in_i,
  input  logic signed [spp_pkg::SAMPLE_WIDTH-1:0] right_in_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [spp_pkg::SAMPLE_WIDTH-1:0] left_out_o,
  output logic signed [spp_pkg::SAMPLE_WIDTH-1:0] right_out_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [spp_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [spp_pkg::CFG_DATA_W-1:0]          cfg_data_i
);
  import spp_pkg::*;

  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic [ADDR_W-1:0] wp_q, wp_d;
  logic              wrap_q, wrap_d;
  logic              hit_q, hit_d;
  logic              out_valid_q, out_valid_d;
  logic signed [SAMPLE_WIDTH-1:0] left_out_q, right_out_q;
  logic              in_ready;
  logic              mem_re, mem_we, deliver;
  logic [ADDR_W:0]   rd_sum;
  logic [ADDR_W-1:0] rd_addr;
  logic [MEM_W-1:0]  rd_data, push;
  logic signed [SAMPLE_WIDTH-1:0] dsp_out_l, dsp_out_r;
  coef_t             coef;
  ctrl_t             ctrl;

  spp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef)
  );

  assign rd_sum = (wp_q >= coef.delay) ? ({1'b0, wp_q} - {1'b0, coef.delay})
                                       : ({1'b0, wp_q} + DEPTH_X - {1'b0, coef.delay});
  assign rd_addr = rd_sum[ADDR_W-1:0];

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    wp_d        = wp_q;
    wrap_d      = wrap_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    in_ready    = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    deliver     = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          state_d = ST_RUN;
          step_d  = S_READ;
        end
      end
      ST_RUN: begin
        if (step_q == S_READ) begin
          mem_re = 1'b1;
          hit_d  = wrap_q || (rd_addr < wp_q);
        end
        if (step_q == S_WET_R) begin
          mem_we = 1'b1;
          if (wp_q == LAST_ADDR) begin
            wp_d   = '0;
            wrap_d = 1'b1;
          end else begin
            wp_d = wp_q + ADDR_W'(1);
          end
        end
        if (step_q == S_DONE) begin
          if (!out_valid_q || out_ready_i) begin
            deliver     = 1'b1;
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end
        end else begin
          step_d = step_e'(step_q + 4'd1);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= S_READ;
      wp_q        <= '0;
      wrap_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      wp_q        <= wp_d;
      wrap_q      <= wrap_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (deliver) begin
      left_out_q  <= dsp_out_l;
      right_out_q <= dsp_out_r;
    end
  end

  assign ctrl.load   = in_valid_i && in_ready;
  assign ctrl.run    = (state_q == ST_RUN);
  assign ctrl.step   = step_q;
  assign ctrl.rd_hit = hit_q;

  spp_ram #(
    .WIDTH (MEM_W),
    .DEPTH (DELAY_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q),
    .wdata_i (push),
    .re_i    (mem_re),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  spp_dsp u_dsp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .coef_i      (coef),
    .left_in_i   (left_in_i),
    .right_in_i  (right_in_i),
    .rd_data_i   (rd_data),
    .push_o      (push),
    .left_out_o  (dsp_out_l),
    .right_out_o (dsp_out_r)
  );

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

endmodule

### rtl/spp_checker.sv
// Port-level checker for the stereo ping-pong delay, bound to the top level.
module spp_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    in_valid_i,
  input logic                                    in_ready_o,
  input logic                                    out_valid_o,
  input logic                                    out_ready_i,
  input logic signed [spp_pkg::SAMPLE_WIDTH-1:0] left_out_o,
  input logic signed [spp_pkg::SAMPLE_WIDTH-1:0] right_out_o
);

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted request");

  a_busy_full_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##15 !in_ready_o)
    else $error("input ready before the item finished");

  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result shown while the datapath is still busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(left_out_o) && $stable(right_out_o))
    else $error("stalled result dropped or changed");

endmodule

bind stereo_pingpong_delay_core spp_checker u_spp_checker (.*);

### sim/testbench.sv
// Testbench for the stereo ping-pong delay core: predictor, scoreboard, stimulus and checks.
module testbench;
  import spp_pkg::*;

  localparam int     HALF_PERIOD  = 4;
  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     DRAIN_CYCLES = 24;
  localparam int     PHASES       = 14;
  localparam int     PHASE_ITEMS  = 52;
  localparam int     HOLD_CYCLES  = 500;
  localparam longint ONE_Q16      = longint'(UNITY);
  localparam longint FB_CAP       = longint'(FB_MAX);
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = 3'd7;
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0] left;
    logic signed [SAMPLE_WIDTH-1:0] right;
  } stereo_t;

  class delay_scoreboard;
    bit signed [SAMPLE_WIDTH-1:0] line_l [DELAY_DEPTH];
    bit signed [SAMPLE_WIDTH-1:0] line_r [DELAY_DEPTH];
    int unsigned       wr_pos;
    longint            damp_l;
    longint            damp_r;
    logic [DLY_W-1:0]  dly_reg;
    logic [FB_W-1:0]   fb_reg;
    logic [GAIN_W-1:0] pp_reg;
    logic [TONE_W-1:0] tone_reg;
    logic [GAIN_W-1:0] wet_reg;
    stereo_t           pending_out[$];
    int                errors;

    function new();
      wr_pos   = 0;
      damp_l   = 0;
      damp_r   = 0;
      dly_reg  = DLY_RESET;
      fb_reg   = '0;
      pp_reg   = '0;
      tone_reg = TONE_RESET;
      wet_reg  = '0;
      errors   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DELAY:    dly_reg  = data[DLY_W-1:0];
        REG_FEEDBACK: fb_reg   = data[FB_W-1:0];
        REG_PINGPONG: pp_reg   = data[GAIN_W-1:0];
        REG_TONE:     tone_reg = data[TONE_W-1:0];
        REG_WET:      wet_reg  = data[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function longint round_q(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function logic signed [SAMPLE_WIDTH-1:0] clip(longint v);
      if (v > longint'(SAMPLE_MAX)) return SAMPLE_MAX;
      if (v < longint'(SAMPLE_MIN)) return SAMPLE_MIN;
      return v[SAMPLE_WIDTH-1:0];
    endfunction

    function void note_request(logic signed [SAMPLE_WIDTH-1:0] l,
                               logic signed [SAMPLE_WIDTH-1:0] r);
      longint      in_l, in_r, tap_l, tap_r, fb, pp, wet, tone, mix_l, mix_r;
      int unsigned d, rd_pos;
      stereo_t     want;
      in_l  = l;
      in_r  = r;
      fb    = (longint'(fb_reg) > FB_CAP) ? FB_CAP : longint'(fb_reg);
      pp    = (longint'(pp_reg) > ONE_Q16) ? ONE_Q16 : longint'(pp_reg);
      wet   = (longint'(wet_reg) > ONE_Q16) ? ONE_Q16 : longint'(wet_reg);
      tone  = longint'(tone_reg);
      d     = dly_reg;
      if (d < 1) d = 1;
      if (d > DELAY_DEPTH - 1) d = DELAY_DEPTH - 1;
      rd_pos = (wr_pos >= d) ? wr_pos - d : wr_pos + DELAY_DEPTH - d;
      tap_l = line_l[rd_pos];
      tap_r = line_r[rd_pos];
      damp_l += round_q(tone * (tap_l - damp_l), FRAC_W);
      damp_r += round_q(tone * (tap_r - damp_r), FRAC_W);
      mix_l = damp_l * (ONE_Q16 - pp) + damp_r * pp;
      mix_r = damp_r * (ONE_Q16 - pp) + damp_l * pp;
      line_l[wr_pos] = clip(in_l + round_q(mix_l * fb, FB_SHIFT));
      line_r[wr_pos] = clip(in_r + round_q(mix_r * fb, FB_SHIFT));
      wr_pos = (wr_pos == DELAY_DEPTH - 1) ? 0 : wr_pos + 1;
      want.left  = clip(in_l + round_q(damp_l * wet, FRAC_W));
      want.right = clip(in_r + round_q(damp_r * wet, FRAC_W));
      pending_out.push_back(want);
    endfunction

    function void check_result(logic signed [SAMPLE_WIDTH-1:0] l,
                               logic signed [SAMPLE_WIDTH-1:0] r);
      stereo_t want;
      if (pending_out.size() == 0) begin
        $error("unexpected result: left_out %0d, right_out %0d", l, r);
        errors++;
        return;
      end
      want = pending_out.pop_front();
      if (l !== want.left) begin
        $error("left_out: expected %0d, actual %0d", want.left, l);
        errors++;
      end
      if (r !== want.right) begin
        $error("right_out: expected %0d, actual %0d", want.right, r);
        errors++;
      end
    endfunction

    function int pending();
      return pending_out.size();
    endfunction
  endclass

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  logic signed [SAMPLE_WIDTH-1:0] left_in_i   = '0;
  logic signed [SAMPLE_WIDTH-1:0] right_in_i  = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] left_out_o;
  logic signed [SAMPLE_WIDTH-1:0] right_out_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [CFG_IDX_W-1:0]           cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]          cfg_data_i  = '0;

  delay_scoreboard board = new();
  int tx_gap_pct     = 0;
  int rx_stall_pct   = 0;
  int rx_hold_cycles = 0;
  int cycles         = 0;

  stereo_pingpong_delay_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .left_in_i   (left_in_i),
    .right_in_i  (right_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #HALF_PERIOD clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      1, 2, 3: return SAMPLE_WIDTH'(int'($urandom_range(4000)) - 2000);
      default: return SAMPLE_WIDTH'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_coef(int unsigned top);
    case ($urandom_range(5))
      0:       return '0;
      1:       return CFG_DATA_W'(top);
      2:       return CFG_DATA_W'($urandom());
      default: return CFG_DATA_W'($urandom_range(top));
    endcase
  endfunction

  // hold valid and payload until the request is taken
  task automatic send_pair(input logic signed [SAMPLE_WIDTH-1:0] l,
                           input logic signed [SAMPLE_WIDTH-1:0] r);
    int gap;
    bit taken;
    gap = pick_gap(tx_gap_pct);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_in_i  <= l;
    right_in_i <= r;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    board.note_request(l, r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    board.set_reg(idx, data);
  endtask

  task automatic write_unused_regs(input logic [CFG_DATA_W-1:0] data);
    for (int i = IDX_UNUSED_LO; i <= IDX_UNUSED_HI; i++) write_reg(CFG_IDX_W'(i), data);
  endtask

  // drop valid and wait for every outstanding result
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure_random();
    logic [CFG_DATA_W-1:0] dly;
    case ($urandom_range(9))
      0:       dly = '0;
      1:       dly = CFG_DATA_W'(DELAY_DEPTH - 1);
      2:       dly = CFG_DATA_W'($urandom());
      3, 4:    dly = CFG_DATA_W'($urandom_range(3000, 65));
      default: dly = CFG_DATA_W'($urandom_range(64, 1));
    endcase
    write_reg(REG_DELAY, dly);
    write_reg(REG_FEEDBACK, pick_coef(32'(FB_CAP)));
    write_reg(REG_PINGPONG, pick_coef(32'(ONE_Q16)));
    write_reg(REG_TONE, pick_coef(32'(TONE_RESET)));
    write_reg(REG_WET, pick_coef(32'(ONE_Q16)));
    if ($urandom_range(3) == 0) write_unused_regs(CFG_DATA_W'($urandom()));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : rx_side
    int stall;
    stall = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        stall = pick_gap(rx_stall_pct);
      end
    end
  end

  always @(negedge clk_i) begin
    if (out_valid_o && out_ready_i) board.check_result(left_out_o, right_out_o);
  end

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    settle();
    write_reg(REG_DELAY, '0);
    write_reg(REG_FEEDBACK, '1);
    write_reg(REG_PINGPONG, '1);
    write_reg(REG_TONE, '1);
    write_reg(REG_WET, '1);
    write_unused_regs('1);
    cfg_valid_i <= 1'b0;
    repeat (4) send_pair(SAMPLE_MAX, SAMPLE_MAX);
    repeat (4) send_pair(SAMPLE_MIN, SAMPLE_MIN);
    repeat (3) send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair('0, '1);
    send_pair('1, '0);
    settle();
    write_reg(REG_DELAY, CFG_DATA_W'(DELAY_DEPTH - 1));
    write_reg(REG_FEEDBACK, CFG_DATA_W'(FB_CAP));
    write_reg(REG_PINGPONG, '0);
    write_reg(REG_TONE, '0);
    write_reg(REG_WET, CFG_DATA_W'(ONE_Q16));
    write_unused_regs('0);
    cfg_valid_i <= 1'b0;
    repeat (3) send_pair(rand_sample(), rand_sample());

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      configure_random();
      tx_gap_pct   = (ph == 0 || ph == 3) ? 0 : 30 * $urandom_range(2);
      rx_stall_pct = (ph == 0) ? 0 : 30 * $urandom_range(2);
      if (ph == 3) rx_hold_cycles = HOLD_CYCLES;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 6 && n == PHASE_ITEMS / 2) settle();
        send_pair(rand_sample(), rand_sample());
      end
    end
    settle();

    if (board.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
